// ===== src/srlh_pkg.sv =====
// ============================================================================
// srlh_pkg - shared definitions for the symbol run-length histogram
// Beat types, character codes, symbol codes and the symbol lookup function.
// ============================================================================
`default_nettype none

package srlh_pkg;

   // Default configuration of the core.
   localparam int MAX_RUN_DEFAULT     = 255;
   localparam int COUNT_WIDTH_DEFAULT = 32;

   // Fixed field widths of the beats.
   localparam int BYTE_W      = 8;
   localparam int SYM_W       = 3;
   localparam int LEN_FIELD_W = 8;
   localparam int BIN_COUNT_W = 32;

   // Number of counted symbols.
   localparam int NUM_SYMS = 5;

   // Character codes.
   localparam logic [BYTE_W-1:0] CHAR_ONE     = 8'h31;
   localparam logic [BYTE_W-1:0] CHAR_TWO     = 8'h32;
   localparam logic [BYTE_W-1:0] CHAR_THREE   = 8'h33;
   localparam logic [BYTE_W-1:0] CHAR_H       = 8'h48;
   localparam logic [BYTE_W-1:0] CHAR_L       = 8'h4C;
   localparam logic [BYTE_W-1:0] CHAR_T       = 8'h54;
   localparam logic [BYTE_W-1:0] CHAR_Q       = 8'h51;
   localparam logic [BYTE_W-1:0] CHAR_C       = 8'h43;
   localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;

   // Symbol codes, used both for bin addressing and in result beats.
   localparam logic [SYM_W-1:0] SYM_H     = 3'd0;
   localparam logic [SYM_W-1:0] SYM_L     = 3'd1;
   localparam logic [SYM_W-1:0] SYM_T     = 3'd2;
   localparam logic [SYM_W-1:0] SYM_Q     = 3'd3;
   localparam logic [SYM_W-1:0] SYM_C     = 3'd4;
   localparam logic [SYM_W-1:0] SYM_COUNT = 3'd5;

   // Input beat.
   typedef struct packed {
      logic                   func;
      logic [BYTE_W-1:0]      symbol_byte;
      logic                   end_of_input;
      logic [SYM_W-1:0]       read_symbol;
      logic [LEN_FIELD_W-1:0] read_length;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [BIN_COUNT_W-1:0] bin_count;
      logic                   run_closed;
      logic [SYM_W-1:0]       closed_symbol;
      logic [LEN_FIELD_W-1:0] closed_length;
   } rsp_type;

   // Result of looking up a byte in the counted symbol set.
   typedef struct packed {
      logic             hit;
      logic [SYM_W-1:0] idx;
   } sym_lookup_type;

   function automatic sym_lookup_type sym_lookup(input logic [BYTE_W-1:0] b);
      sym_lookup_type r;
      r.hit = 1'b1;
      r.idx = SYM_H;
      unique case (b)
         CHAR_H:  r.idx = SYM_H;
         CHAR_L:  r.idx = SYM_L;
         CHAR_T:  r.idx = SYM_T;
         CHAR_Q:  r.idx = SYM_Q;
         CHAR_C:  r.idx = SYM_C;
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/srlh_ram.sv =====
// ============================================================================
// srlh_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of the entry being
// written in the same cycle returns the old contents.
// ============================================================================
`default_nettype none

module srlh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1280
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== src/symbol_run_length_histogram_core.sv =====
// ============================================================================
// symbol_run_length_histogram_core - run-length histogram of a symbol stream
// Tracks runs of equal bytes and counts finished H, L, T, Q and C runs per
// length in a bin memory; read beats return one bin.
// ============================================================================
// Path: an accepted beat passes through the update stage and the result queue to rsp_valid.
// Throughput: one beat per cycle while req_ready is high; the bin memory is read at
//   acceptance and written back in the next cycle, with the written value forwarded.
// Reset: run state clears at once; then a clearing pass writes zero to all
//   5 * 2**ceil(log2(MAX_RUN+1)) bins (1280 by default), one per cycle,
//   while req_ready stays low.
`default_nettype none

module symbol_run_length_histogram_core import srlh_pkg::*; #(
   parameter int MAX_RUN     = MAX_RUN_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_payload,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_payload
);

   // Bins are addressed as {symbol, length}; lengths are padded to a power
   // of two so that no multiply is needed to form the address.
   localparam int LEN_W     = $clog2(MAX_RUN + 1);
   localparam int DEPTH     = NUM_SYMS << LEN_W;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int OUT_DEPTH = 3;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [1:0]             OUT_LAST  = 2'(OUT_DEPTH - 1);

   // ---------------------------------------------------------------------
   // Run state. These registers are updated at acceptance, so the next
   // beat always sees the run state left by the previous one.
   // ---------------------------------------------------------------------
   logic [BYTE_W-1:0] last_byte_ff, last_byte_in;
   logic              run_open_ff,  run_open_in;
   logic [LEN_W-1:0]  run_count_ff, run_count_in;

   logic              accept;
   logic [BYTE_W-1:0] mapped_byte;
   sym_lookup_type    last_sym;
   logic              close_run;
   logic              count_run;
   logic              rd_ok;
   logic [ADDR_W-1:0] ram_rd_addr;

   assign accept   = req_valid && req_ready;
   assign last_sym = sym_lookup(last_byte_ff);

   // The digits one, two and three all stand for the C symbol.
   always_comb begin
      mapped_byte = req_payload.symbol_byte;
      if (req_payload.symbol_byte == CHAR_ONE || req_payload.symbol_byte == CHAR_TWO ||
          req_payload.symbol_byte == CHAR_THREE) begin
         mapped_byte = CHAR_C;
      end
   end

   // Run tracking. A feed beat either extends the open run or closes it; a
   // newline or the end of input closes it without opening a new one.
   always_comb begin
      last_byte_in = last_byte_ff;
      run_open_in  = run_open_ff;
      run_count_in = run_count_ff;
      close_run    = 1'b0;
      if (accept && !req_payload.func) begin
         if (req_payload.end_of_input) begin
            close_run   = run_open_ff;
            run_open_in = 1'b0;
         end else if (run_open_ff && mapped_byte == last_byte_ff) begin
            if (run_count_ff < LEN_W'(MAX_RUN)) begin
               run_count_in = run_count_ff + 1'b1;
            end
         end else begin
            close_run = run_open_ff;
            if (mapped_byte == CHAR_NEWLINE) begin
               run_open_in = 1'b0;
            end else begin
               run_open_in  = 1'b1;
               last_byte_in = mapped_byte;
               run_count_in = LEN_W'(1);
            end
         end
      end
   end

   // Only runs of the five counted symbols reach the histogram.
   assign count_run = close_run && last_sym.hit;

   // A read of a symbol or a length outside the histogram returns zero.
   assign rd_ok = (req_payload.read_symbol < SYM_COUNT) &&
                  (32'(req_payload.read_length) <= 32'(MAX_RUN));

   // The bin memory is read in the accepting cycle, for a read beat at the
   // requested bin and for a feed beat at the bin of the run it closes.
   always_comb begin
      if (req_payload.func) begin
         ram_rd_addr = rd_ok ? {req_payload.read_symbol, LEN_W'(req_payload.read_length)}
                             : '0;
      end else begin
         ram_rd_addr = {last_sym.idx, run_count_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_byte_ff <= '0;
         run_open_ff  <= 1'b0;
         run_count_ff <= '0;
      end else begin
         last_byte_ff <= last_byte_in;
         run_open_ff  <= run_open_in;
         run_count_ff <= run_count_in;
      end
   end

   // ---------------------------------------------------------------------
   // Clearing pass after reset: every bin is written with zero, one per
   // cycle, before the first request beat is taken.
   // ---------------------------------------------------------------------
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // ---------------------------------------------------------------------
   // Update stage. The bin read at acceptance arrives here; a closed counted
   // run increments it (saturating) and writes it back in this same cycle.
   // ---------------------------------------------------------------------
   logic                   s1_valid_ff;
   logic                   s1_rd_ff;
   logic                   s1_rd_ok_ff;
   logic                   s1_inc_ff;
   logic [ADDR_W-1:0]      s1_addr_ff;
   logic [SYM_W-1:0]       s1_sym_ff;
   logic [LEN_FIELD_W-1:0] s1_len_ff;

   // Forwarding: the memory returns old data for an entry written in the
   // cycle it is read, so the value written by the update stage is kept
   // for the beat that read the same bin in that cycle.
   logic                   fwd_hit_ff, fwd_hit_in;
   logic [COUNT_WIDTH-1:0] fwd_data_ff;

   logic [COUNT_WIDTH-1:0] ram_rd_data;
   logic [COUNT_WIDTH-1:0] bin_q;
   logic [COUNT_WIDTH-1:0] bin_inc;
   logic                   ram_wr_en;
   logic [ADDR_W-1:0]      ram_wr_addr;
   logic [COUNT_WIDTH-1:0] ram_wr_data;
   rsp_type                s1_rsp;

   assign bin_q   = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
   assign bin_inc = (bin_q == COUNT_MAX) ? bin_q : bin_q + 1'b1;

   assign fwd_hit_in = accept && s1_valid_ff && s1_inc_ff && (ram_rd_addr == s1_addr_ff);

   always_comb begin
      if (clearing_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = s1_valid_ff && s1_inc_ff;
         ram_wr_addr = s1_addr_ff;
         ram_wr_data = bin_inc;
      end
   end

   srlh_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (DEPTH)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      s1_rsp.bin_count     = (s1_rd_ff && s1_rd_ok_ff) ? BIN_COUNT_W'(bin_q) : '0;
      s1_rsp.run_closed    = s1_inc_ff;
      s1_rsp.closed_symbol = s1_sym_ff;
      s1_rsp.closed_length = s1_len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         fwd_hit_ff  <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= bin_inc;
      if (accept) begin
         s1_rd_ff    <= req_payload.func;
         s1_rd_ok_ff <= rd_ok;
         s1_inc_ff   <= count_run;
         s1_addr_ff  <= ram_rd_addr;
         s1_sym_ff   <= count_run ? last_sym.idx : '0;
         s1_len_ff   <= count_run ? LEN_FIELD_W'(run_count_ff) : '0;
      end
   end

   // ---------------------------------------------------------------------
   // Result queue. The update stage never stalls: a request beat is taken
   // only while the stage and the queue together hold fewer than
   // OUT_DEPTH beats, so a free slot always waits for the stage's result.
   // ---------------------------------------------------------------------
   rsp_type    out_fifo_ff [OUT_DEPTH];
   logic [1:0] out_wr_ptr_ff, out_wr_ptr_in;
   logic [1:0] out_rd_ptr_ff, out_rd_ptr_in;
   logic [1:0] out_count_ff,  out_count_in;
   logic       out_push;
   logic       out_pop;

   assign out_push = s1_valid_ff;
   assign out_pop  = rsp_valid && rsp_ready;

   assign rsp_valid   = (out_count_ff != 2'd0);
   assign rsp_payload = out_fifo_ff[out_rd_ptr_ff];
   assign req_ready   = !clearing_ff &&
                        ((3'(s1_valid_ff) + 3'(out_count_ff)) < 3'(OUT_DEPTH));

   always_comb begin
      out_wr_ptr_in = out_wr_ptr_ff;
      out_rd_ptr_in = out_rd_ptr_ff;
      out_count_in  = out_count_ff;
      if (out_push) begin
         out_wr_ptr_in = (out_wr_ptr_ff == OUT_LAST) ? 2'd0 : out_wr_ptr_ff + 2'd1;
      end
      if (out_pop) begin
         out_rd_ptr_in = (out_rd_ptr_ff == OUT_LAST) ? 2'd0 : out_rd_ptr_ff + 2'd1;
      end
      if (out_push && !out_pop) begin
         out_count_in = out_count_ff + 2'd1;
      end else if (out_pop && !out_push) begin
         out_count_in = out_count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ptr_ff <= '0;
         out_rd_ptr_ff <= '0;
         out_count_ff  <= '0;
      end else begin
         out_wr_ptr_ff <= out_wr_ptr_in;
         out_rd_ptr_ff <= out_rd_ptr_in;
         out_count_ff  <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_fifo_ff[out_wr_ptr_ff] <= s1_rsp;
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // The beats in flight never exceed the result queue, so a push always
   // finds room.
   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      (3'(s1_valid_ff) + 3'(out_count_ff)) <= 3'(OUT_DEPTH))
      else $error("beats in flight exceed the result queue");

   // No request beat is taken while the bins are still being cleared.
   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_ready)
      else $error("request accepted during the clearing pass");

   // A forwarded value always belongs to a beat in the update stage.
   a_fwd_has_beat: assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> s1_valid_ff)
      else $error("forwarding flagged without a beat in the update stage");

   // A counted run is never shorter than one byte.
   a_inc_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_inc_ff) |-> (s1_addr_ff[LEN_W-1:0] != '0))
      else $error("bin of length zero incremented");

   // A beat accepted now is pushed into the result queue at the next edge.
   a_accept_to_push: assert property (@(posedge clock) disable iff (reset)
      accept |=> out_push)
      else $error("accepted beat did not reach the result queue");

endmodule

`default_nettype wire

// ===== tb/symbol_run_length_histogram_core_test.sv =====
// ============================================================================
// symbol_run_length_histogram_core_test - self-checking bench for the core
// Feeds symbol bytes and bin reads through the request channel, predicts each
// result beat with a behavioral model of the run tracker and histogram, and
// compares every result beat field by field, with random idling on both sides.
// ============================================================================
`timescale 1ns / 100ps

module symbol_run_length_histogram_core_test;
   import srlh_pkg::*;

   // Encodings of the func field of a request beat.
   localparam logic FUNC_FEED = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // About 1400 request beats in all, the directed part included.
   localparam int ITEM_TARGET = 1400;
   // The long receiver hold-off starts once this many results have arrived.
   localparam int HOLD_AT_RESULT = 400;
   localparam int HOLD_CYCLES    = 150;
   // Hard limit on the run time, far above what the slowest legal run needs.
   localparam int TIMEOUT_NS     = 1000000;

   // One row of the directed table. Where typed is set, the expected result
   // is the one written into the row; otherwise the predictor supplies it.
   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type result;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   // Predictor state: the open run and the full histogram.
   logic [BYTE_W-1:0]      open_byte;
   bit                     run_is_open;
   int                     open_length;
   logic [BIN_COUNT_W-1:0] length_bins [NUM_SYMS][MAX_RUN_DEFAULT+1];

   // Results the core still owes us, oldest first.
   rsp_type      expected_results [$];
   stim_row_type directed_rows [$];

   int error_count    = 0;
   int beats_sent     = 0;
   int results_seen   = 0;
   int reads_sent     = 0;
   int runs_closed    = 0;
   int runs_saturated = 0;
   int send_calm      = 0;
   int recv_calm      = 0;

   symbol_run_length_histogram_core #(
      .MAX_RUN     (MAX_RUN_DEFAULT),
      .COUNT_WIDTH (COUNT_WIDTH_DEFAULT)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Hard stop in case the core hangs or drops a result beat.
   initial begin
      #(TIMEOUT_NS);
      $display("status: fail");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor. Works out the result of one accepted request beat and moves
   // the run tracker and histogram along with it.
   // ---------------------------------------------------------------------
   function automatic rsp_type tally_run_lengths(req_type beat);
      rsp_type          r;
      logic [BYTE_W-1:0] b;
      logic [SYM_W-1:0]  sym;
      bit                counted;
      r = '0;
      if (beat.func == FUNC_READ) begin
         // Reads touch nothing; out-of-range symbols or lengths read as zero.
         reads_sent++;
         if (beat.read_symbol < NUM_SYMS && beat.read_length <= MAX_RUN_DEFAULT)
            r.bin_count = length_bins[beat.read_symbol][beat.read_length];
         return r;
      end
      // The digits 1, 2 and 3 are just other spellings of C.
      b = beat.symbol_byte;
      if (b inside {CHAR_ONE, CHAR_TWO, CHAR_THREE})
         b = CHAR_C;
      // An equal byte extends the open run, holding at the length limit.
      if (!beat.end_of_input && run_is_open && b == open_byte) begin
         if (open_length < MAX_RUN_DEFAULT)
            open_length++;
         return r;
      end
      // Anything else closes the open run; only the five symbols are binned.
      if (run_is_open) begin
         run_is_open = 1'b0;
         counted     = 1'b1;
         sym         = SYM_H;
         case (open_byte)
            CHAR_H:  sym = SYM_H;
            CHAR_L:  sym = SYM_L;
            CHAR_T:  sym = SYM_T;
            CHAR_Q:  sym = SYM_Q;
            CHAR_C:  sym = SYM_C;
            default: counted = 1'b0;
         endcase
         if (counted) begin
            if (length_bins[sym][open_length] != '1)
               length_bins[sym][open_length]++;
            r.run_closed    = 1'b1;
            r.closed_symbol = sym;
            r.closed_length = LEN_FIELD_W'(open_length);
            runs_closed++;
            if (open_length == MAX_RUN_DEFAULT)
               runs_saturated++;
         end
      end
      // End of input and newline leave no run open; any other byte opens one.
      if (!beat.end_of_input && b != CHAR_NEWLINE) begin
         run_is_open = 1'b1;
         open_byte   = b;
         open_length = 1;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Beat builders. Fields that the operation ignores carry random bits so
   // that the core is seen to ignore them.
   // ---------------------------------------------------------------------
   function automatic req_type random_beat();
      logic [31:0]                draw;
      logic [$bits(req_type)-1:0] raw;
      draw = $urandom;
      raw  = draw[$bits(req_type)-1:0];
      return raw;
   endfunction

   function automatic req_type feed_beat(logic [BYTE_W-1:0] b);
      req_type beat;
      beat              = random_beat();
      beat.func         = FUNC_FEED;
      beat.end_of_input = 1'b0;
      beat.symbol_byte  = b;
      return beat;
   endfunction

   function automatic req_type end_beat(logic [BYTE_W-1:0] b);
      req_type beat;
      beat              = random_beat();
      beat.func         = FUNC_FEED;
      beat.end_of_input = 1'b1;
      beat.symbol_byte  = b;
      return beat;
   endfunction

   function automatic req_type read_beat(logic [SYM_W-1:0] s, logic [LEN_FIELD_W-1:0] l);
      req_type beat;
      beat             = random_beat();
      beat.func        = FUNC_READ;
      beat.read_symbol = s;
      beat.read_length = l;
      return beat;
   endfunction

   function automatic rsp_type closed_result(logic [SYM_W-1:0] s, logic [LEN_FIELD_W-1:0] l);
      rsp_type r;
      r               = '0;
      r.run_closed    = 1'b1;
      r.closed_symbol = s;
      r.closed_length = l;
      return r;
   endfunction

   function automatic rsp_type count_result(logic [BIN_COUNT_W-1:0] n);
      rsp_type r;
      r           = '0;
      r.bin_count = n;
      return r;
   endfunction

   task automatic add_row(req_type beat, bit typed, rsp_type result);
      stim_row_type row;
      row.beat   = beat;
      row.typed  = typed;
      row.result = result;
      directed_rows.push_back(row);
   endtask

   // Idle cycles before the next beat on one side. Now and then a side goes
   // through a calm stretch of back-to-back beats.
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 6);
   endfunction

   // Offer one request beat and hold it until the core takes it. The
   // expectation is queued at the accepting edge, so the queue order is
   // the order in which the core saw the beats.
   task automatic offer(req_type beat, bit typed, rsp_type typed_result);
      int      gap;
      rsp_type predicted;
      gap = draw_gap(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = tally_run_lengths(beat);
      expected_results.push_back(typed ? typed_result : predicted);
      beats_sent++;
   endtask

   task automatic compare_result(rsp_type got);
      rsp_type want;
      if (expected_results.size() == 0) begin
         error_count++;
         $error("result beat with no request waiting for it: %h", got);
         return;
      end
      want = expected_results.pop_front();
      if (got.bin_count !== want.bin_count) begin
         error_count++;
         $error("bin_count: expected %0d, got %0d", want.bin_count, got.bin_count);
      end
      if (got.run_closed !== want.run_closed) begin
         error_count++;
         $error("run_closed: expected %0d, got %0d", want.run_closed, got.run_closed);
      end
      if (got.closed_symbol !== want.closed_symbol) begin
         error_count++;
         $error("closed_symbol: expected %0d, got %0d", want.closed_symbol,
                got.closed_symbol);
      end
      if (got.closed_length !== want.closed_length) begin
         error_count++;
         $error("closed_length: expected %0d, got %0d", want.closed_length,
                got.closed_length);
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver. Stalls at random, and once holds off for a long stretch so
   // that the core backs up and drops req_ready while beats keep coming.
   // ---------------------------------------------------------------------
   initial begin
      int  stall;
      bit  held_off;
      held_off = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = draw_gap(recv_calm);
         if (!held_off && results_seen >= HOLD_AT_RESULT) begin
            held_off = 1'b1;
            stall    = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         compare_result(rsp_payload);
         results_seen++;
      end
   end

   // ---------------------------------------------------------------------
   // Sender and run control.
   // ---------------------------------------------------------------------
   initial begin
      logic [BYTE_W-1:0] sym_chars [NUM_SYMS];
      logic [BYTE_W-1:0] c_forms [4];
      logic [BYTE_W-1:0] b;
      logic [SYM_W-1:0]  s;
      logic [LEN_FIELD_W-1:0] l;
      int pick;
      int run_len;

      sym_chars = '{CHAR_H, CHAR_L, CHAR_T, CHAR_Q, CHAR_C};
      c_forms   = '{CHAR_C, CHAR_ONE, CHAR_TWO, CHAR_THREE};

      // The histogram comes out of reset all zero with nothing open.
      run_is_open = 1'b0;
      open_byte   = '0;
      open_length = 0;
      foreach (length_bins[i, j])
         length_bins[i][j] = '0;

      // Directed table. Rows whose result is obvious carry it; the rest
      // lean on the predictor.
      // Reads straight after reset: both length extremes, an invalid symbol.
      add_row(read_beat(SYM_H, 8'd0),   1'b1, count_result(32'd0));
      add_row(read_beat(SYM_C, 8'hFF),  1'b1, count_result(32'd0));
      add_row(read_beat(3'd7, 8'd5),    1'b1, count_result(32'd0));
      // A run of two H is closed by L; the L run is closed by a digit.
      add_row(feed_beat(CHAR_H),        1'b1, '0);
      add_row(feed_beat(CHAR_H),        1'b1, '0);
      add_row(feed_beat(CHAR_L),        1'b1, closed_result(SYM_H, 8'd2));
      add_row(feed_beat(CHAR_ONE),      1'b1, closed_result(SYM_L, 8'd1));
      // All digits and C form one run of four.
      add_row(feed_beat(CHAR_TWO),      1'b0, '0);
      add_row(feed_beat(CHAR_THREE),    1'b0, '0);
      add_row(feed_beat(CHAR_C),        1'b0, '0);
      // Newline closes the run; a second newline has nothing to close.
      add_row(feed_beat(CHAR_NEWLINE),  1'b1, closed_result(SYM_C, 8'd4));
      add_row(feed_beat(CHAR_NEWLINE),  1'b1, '0);
      // End of input with no run open, then one closing a T run even though
      // its byte matches the run.
      add_row(end_beat(8'hFF),          1'b1, '0);
      add_row(feed_beat(CHAR_T),        1'b1, '0);
      add_row(end_beat(CHAR_T),         1'b1, closed_result(SYM_T, 8'd1));
      // A run of some other byte ends silently.
      add_row(feed_beat("x"),           1'b1, '0);
      add_row(feed_beat("x"),           1'b0, '0);
      add_row(feed_beat(CHAR_Q),        1'b1, '0);
      // Byte extremes.
      add_row(feed_beat(8'h00),         1'b1, closed_result(SYM_Q, 8'd1));
      add_row(feed_beat(8'hFF),         1'b0, '0);
      add_row(feed_beat(CHAR_H),        1'b0, '0);
      // Bins that the runs above have filled.
      add_row(read_beat(SYM_H, 8'd2),   1'b1, count_result(32'd1));
      add_row(read_beat(SYM_C, 8'd4),   1'b1, count_result(32'd1));
      add_row(read_beat(SYM_L, 8'd1),   1'b1, count_result(32'd1));
      add_row(end_beat(8'h00),          1'b0, '0);

      // Synchronous reset; the core then clears its bins on its own and holds
      // req_ready low until it is done.
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].result);

      // One run well past the length limit, so the length saturates.
      repeat (MAX_RUN_DEFAULT + 15) offer(feed_beat(CHAR_T), 1'b0, '0);

      // Random part: mostly symbol runs of random length and content, with
      // bin reads, newlines, end markers and noise mixed in.
      while (beats_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            b       = sym_chars[$urandom_range(0, NUM_SYMS - 1)];
            run_len = ($urandom_range(0, 49) == 0) ? $urandom_range(200, 300)
                                                   : $urandom_range(1, 6);
            repeat (run_len) begin
               // C runs are spelled with any mix of C and the three digits.
               offer(feed_beat(b == CHAR_C ? c_forms[$urandom_range(0, 3)] : b),
                     1'b0, '0);
            end
         end else if (pick < 78) begin
            s = ($urandom_range(0, 9) == 0) ? SYM_W'($urandom_range(NUM_SYMS, 7))
                                            : SYM_W'($urandom_range(0, NUM_SYMS - 1));
            case ($urandom_range(0, 9))
               0:       l = LEN_FIELD_W'(MAX_RUN_DEFAULT);
               1:       l = LEN_FIELD_W'($urandom);
               default: l = LEN_FIELD_W'($urandom_range(0, 8));
            endcase
            offer(read_beat(s, l), 1'b0, '0);
         end else if (pick < 86) begin
            offer(feed_beat(CHAR_NEWLINE), 1'b0, '0);
         end else if (pick < 91) begin
            offer(end_beat(BYTE_W'($urandom)), 1'b0, '0);
         end else begin
            b = BYTE_W'($urandom);
            repeat ($urandom_range(1, 4)) offer(feed_beat(b), 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      // Drain: wait for every owed result, then keep the bench running so that
      // any stray beat is caught.
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run covered %0d request beats: %0d bin reads and %0d closed symbol runs,",
               beats_sent, reads_sent, runs_closed);
      $display("%0d of those runs at the length limit, plus one long receiver hold-off.",
               runs_saturated);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
